[src/ccc_pkg.sv]
// Package with the shared types and constants of the conductivity core.
package ccc_pkg;

	localparam int SLOPE_SCALE = 10;
	localparam int COMP_SHIFT  = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic signed [15:0] TEMP_REF   = 16'sd250;
	localparam logic signed [15:0] COMP_UNITY = 16'sd10000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd5;

	// Status codes of a result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NEG      = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;

	// Widths of the division datapath.
	localparam int NUM_W = 64;  // numerator magnitude bits
	localparam int DEN_W = 32;  // divisor magnitude bits

	typedef struct packed {
		logic signed [31:0] current_integral;
		logic signed [31:0] voltage_integral;
		logic signed [15:0] temperature_tenths;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] conductivity;
		logic [1:0]         status;
	} out_beat_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [15:0] offset;
		logic [15:0]        temp_coefficient;
		logic               compensate_enable;
		logic signed [15:0] result_min;
		logic signed [15:0] result_max;
	} cfg_t;

	// Control word that travels down the divider pipeline beside the partial
	// quotient.
	typedef struct packed {
		logic       neg_q;
		logic       zero_div;
		logic [1:0] status;
	} div_ctl_t;

endpackage

[src/ccc_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per stage, a register per stage.
module ccc_div_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [ccc_pkg::NUM_W-1:0]     num,
	input  logic [ccc_pkg::DEN_W-1:0]     den,
	input  ccc_pkg::div_ctl_t             ctl_in,
	input  logic [15:0]                   aux_in,
	output logic                          out_valid,
	output logic [ccc_pkg::NUM_W-1:0]     quo,
	output ccc_pkg::div_ctl_t             ctl_out,
	output logic [15:0]                   aux_out
);

	localparam int N = ccc_pkg::NUM_W;
	localparam int D = ccc_pkg::DEN_W;

	// Each stage holds the shifting numerator/quotient word and the partial remainder.
	logic                  v_s1   [N+1];
	logic [N-1:0]          q_s1   [N+1];
	logic [D:0]            r_s1   [N+1];
	logic [D-1:0]          d_s1   [N+1];
	ccc_pkg::div_ctl_t     c_s1   [N+1];
	logic [15:0]           a_s1   [N+1];

	always_comb begin
		v_s1[0] = in_valid;
		q_s1[0] = num;
		r_s1[0] = '0;
		d_s1[0] = den;
		c_s1[0] = ctl_in;
		a_s1[0] = aux_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [D:0] shifted;
		logic [D+1:0] diff;
		logic [D:0] r_next;
		logic       bit_q;

		always_comb begin
			shifted = {r_s1[k][D-1:0], q_s1[k][N-1]};
			diff    = {1'b0, shifted} - {2'b00, d_s1[k]};
			bit_q   = ~diff[D+1];
			r_next  = bit_q ? diff[D:0] : shifted;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (adv) begin
				v_s1[k+1] <= v_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_s1[k+1] <= {q_s1[k][N-2:0], bit_q};
				r_s1[k+1] <= r_next;
				d_s1[k+1] <= d_s1[k];
				c_s1[k+1] <= c_s1[k];
				a_s1[k+1] <= a_s1[k];
			end
		end
	end

	assign out_valid = v_s1[N];
	assign quo       = q_s1[N];
	assign ctl_out   = c_s1[N];
	assign aux_out   = a_s1[N];

endmodule

[src/ccc_front.sv]
// Front stages: slope product, shift, sign handling and the compensation factor.
module ccc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  ccc_pkg::in_beat_t          in_beat,
	input  ccc_pkg::cfg_t              cfg,
	output logic                       out_valid,
	output logic [ccc_pkg::NUM_W-1:0]  num,
	output logic [ccc_pkg::DEN_W-1:0]  den,
	output ccc_pkg::div_ctl_t          ctl,
	output logic signed [31:0]         factor
);

	// Stage 1: product of current and slope, and coefficient product.
	logic               v_s1;
	logic signed [63:0] prod_s1;
	logic [31:0]        volt_s1;
	logic               neg_s1;
	logic               vzero_s1;
	logic signed [32:0] tprod_s1;

	logic signed [16:0] tdiff;
	always_comb tdiff = 17'(in_beat.temperature_tenths) - 17'(ccc_pkg::TEMP_REF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= in_beat.current_integral * cfg.slope;
			volt_s1  <= in_beat.voltage_integral;
			neg_s1   <= in_beat.current_integral[31] | in_beat.voltage_integral[31];
			vzero_s1 <= in_beat.voltage_integral == '0;
			tprod_s1 <= $signed({1'b0, cfg.temp_coefficient}) * tdiff;
		end
	end

	// Stage 2: floor shift; take magnitude of the dividend.
	logic signed [63:0] shifted;
	always_comb shifted = prod_s1 >>> ccc_pkg::SLOPE_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num          <= (neg_s1 || vzero_s1) ? '0 :
				(shifted[63] ? 64'(-shifted) : 64'(shifted));
			den          <= (neg_s1 || vzero_s1) ? 32'd1 : volt_s1;
			ctl.neg_q    <= shifted[63] & ~neg_s1 & ~vzero_s1;
			ctl.zero_div <= ~neg_s1 & vzero_s1;
			ctl.status   <= neg_s1 ? ccc_pkg::ST_NEG :
				(vzero_s1 ? ccc_pkg::ST_ZERO_DIV : ccc_pkg::ST_OK);
			factor       <= 32'(tprod_s1 >>> ccc_pkg::COMP_SHIFT) + 32'(ccc_pkg::COMP_UNITY);
		end
	end

endmodule

[src/ccc_back.sv]
// Back stages: offset, saturate, scale by 10000, second division and clamp.
module ccc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [ccc_pkg::NUM_W-1:0]  quo,
	input  ccc_pkg::div_ctl_t          ctl_in,
	input  logic signed [31:0]         factor,
	input  ccc_pkg::cfg_t              cfg,
	output logic                       out_valid,
	output ccc_pkg::out_beat_t         out_beat
);

	// Stage A: signed quotient plus offset, saturated to +-2^40.
	// A negative integral forces the raw value to zero, so no offset is added.
	logic signed [64:0] raw;
	logic signed [41:0] sat;
	always_comb begin
		raw = ctl_in.neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		raw = raw + ((ctl_in.status == ccc_pkg::ST_NEG) ? 65'sd0 : 65'(cfg.offset));
		if (raw > 65'sd1099511627776) sat = 42'sd1099511627776;
		else if (raw < -65'sd1099511627776) sat = -42'sd1099511627776;
		else sat = 42'(raw);
	end

	logic               va_s1;
	logic signed [41:0] sat_s1;
	logic signed [31:0] fac_s1;
	ccc_pkg::div_ctl_t  c_s1;
	logic               fzero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_s1 <= 1'b0;
		else if (adv) va_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s1   <= sat;
			fac_s1   <= factor;
			c_s1     <= ctl_in;
			fzero_s1 <= factor == '0;
		end
	end

	// Stage B: product by the unity constant and magnitudes for the divider.
	logic signed [56:0] scaled;
	always_comb scaled = sat_s1 * 57'(ccc_pkg::COMP_UNITY);

	logic                      vb_s2;
	logic [ccc_pkg::NUM_W-1:0] num_s2;
	logic [ccc_pkg::DEN_W-1:0] den_s2;
	ccc_pkg::div_ctl_t         c_s2;
	logic signed [41:0]        raw_s2;
	logic                      comp;

	always_comb comp = cfg.compensate_enable & ~c_s1.zero_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb_s2 <= 1'b0;
		else if (adv) vb_s2 <= va_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s2 <= sat_s1;
			if (comp && !fzero_s1) begin
				num_s2     <= 64'(scaled[56] ? -scaled : scaled);
				den_s2     <= fac_s1[31] ? 32'(-fac_s1) : 32'(fac_s1);
				c_s2.neg_q <= scaled[56] ^ fac_s1[31];
			end else begin
				num_s2     <= '0;
				den_s2     <= 32'd1;
				c_s2.neg_q <= 1'b0;
			end
			c_s2.zero_div <= c_s1.zero_div | (comp & fzero_s1);
			c_s2.status   <= (comp & fzero_s1) ? ccc_pkg::ST_ZERO_DIV : c_s1.status;
		end
	end

	// The uncompensated value is carried as a clamped value in aux. The min clamp
	// comes first, so an inverted window still ends at the max.
	logic [15:0] aux_in, aux_out;
	logic        comp_s2;
	always_ff @(posedge clk) begin
		if (adv) comp_s2 <= comp;
	end
	always_comb begin
		if (raw_s2 < 42'(cfg.result_min)) aux_in = (cfg.result_min > cfg.result_max) ?
			cfg.result_max : cfg.result_min;
		else if (raw_s2 > 42'(cfg.result_max)) aux_in = cfg.result_max;
		else aux_in = raw_s2[15:0];
	end

	logic                      vd;
	logic [ccc_pkg::NUM_W-1:0] q2;
	ccc_pkg::div_ctl_t         c_d;
	ccc_pkg::div_ctl_t         c_in2;
	always_comb begin
		c_in2 = c_s2;
		// The control word goes down the divider unchanged; the bypass flag has its own lane.
	end

	logic byp_q [ccc_pkg::NUM_W+1];
	always_comb byp_q[0] = ~comp_s2;
	for (genvar k = 0; k < ccc_pkg::NUM_W; k++) begin : g_byp
		always_ff @(posedge clk) begin
			if (adv) byp_q[k+1] <= byp_q[k];
		end
	end

	ccc_div_pipe u_div2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vb_s2),
		.num(num_s2), .den(den_s2), .ctl_in(c_in2), .aux_in(aux_in),
		.out_valid(vd), .quo(q2), .ctl_out(c_d), .aux_out(aux_out)
	);

	// Final stage: sign, clamp and select.
	logic signed [64:0] v2;
	logic signed [15:0] res;
	always_comb begin
		v2 = c_d.neg_q ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
		if (c_d.zero_div) res = cfg.result_max;
		else if (byp_q[ccc_pkg::NUM_W]) res = aux_out;
		else if (v2 < 65'(cfg.result_min)) res = (65'(cfg.result_min) > 65'(cfg.result_max)) ?
			cfg.result_max : cfg.result_min;
		else if (v2 > 65'(cfg.result_max)) res = cfg.result_max;
		else res = v2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vd;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_beat.conductivity <= res;
			out_beat.status       <= c_d.status;
		end
	end

endmodule

[src/conductivity_calibrate_compensate_core.sv]
// Top level of the conductivity calibration and temperature compensation core.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   in       | in_valid / in_stall    | current, voltage, temperature
//   out      | out_valid / out_stall  | conductivity, status
//   cfg      | cfg_we                 | cfg_index, cfg_data
//
// One beat enters every cycle when the output is not stalled. The pipeline holds
// the two bit-serial divider pipelines (64 stages each), the two front stages,
// the two back offset/scale stages and the output register: 133 register stages.
// The whole pipeline advances together; a stall on the output while it holds a beat
// freezes every stage, so nothing is lost or repeated. The input is stalled only
// when the output register holds a beat and the output side stalls.
// Reset clears all valid bits and loads the register defaults.
module conductivity_calibrate_compensate_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ccc_pkg::in_beat_t                   in_beat,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ccc_pkg::out_beat_t                  out_beat,
	input  logic                                cfg_we,
	input  logic [ccc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ccc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	ccc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope             <= 32'sd771072;
			cfg_q.offset            <= -16'sd1;
			cfg_q.temp_coefficient  <= 16'd2688;
			cfg_q.compensate_enable <= 1'b1;
			cfg_q.result_min        <= 16'sd0;
			cfg_q.result_max        <= 16'sd32767;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccc_pkg::REG_SLOPE:  cfg_q.slope             <= cfg_data;
				ccc_pkg::REG_OFFSET: cfg_q.offset            <= cfg_data[15:0];
				ccc_pkg::REG_COEF:   cfg_q.temp_coefficient  <= cfg_data[15:0];
				ccc_pkg::REG_ENABLE: cfg_q.compensate_enable <= cfg_data[0];
				ccc_pkg::REG_MIN:    cfg_q.result_min        <= cfg_data[15:0];
				ccc_pkg::REG_MAX:    cfg_q.result_max        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the final register is empty or being drained.
	logic adv;
	assign adv      = ~(out_valid & out_stall);
	assign in_stall = ~adv;

	logic                      f_valid;
	logic [ccc_pkg::NUM_W-1:0] f_num;
	logic [ccc_pkg::DEN_W-1:0] f_den;
	ccc_pkg::div_ctl_t         f_ctl;
	logic signed [31:0]        f_factor;

	ccc_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(in_valid), .in_beat(in_beat),
		.cfg(cfg_q), .out_valid(f_valid), .num(f_num), .den(f_den), .ctl(f_ctl),
		.factor(f_factor)
	);

	// The factor rides alongside the first divider: its low half in the aux lane, its high half in a separate chain.
	logic                      d_valid;
	logic [ccc_pkg::NUM_W-1:0] d_quo;
	ccc_pkg::div_ctl_t         d_ctl;
	logic [15:0]               fac_hi, fac_lo;

	ccc_div_pipe u_div1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(f_valid),
		.num(f_num), .den(f_den), .ctl_in(f_ctl), .aux_in(f_factor[15:0]),
		.out_valid(d_valid), .quo(d_quo), .ctl_out(d_ctl), .aux_out(fac_lo)
	);

	logic [15:0] fhi_q [ccc_pkg::NUM_W+1];
	always_comb fhi_q[0] = f_factor[31:16];
	for (genvar k = 0; k < ccc_pkg::NUM_W; k++) begin : g_fhi
		always_ff @(posedge clk) begin
			if (adv) fhi_q[k+1] <= fhi_q[k];
		end
	end
	assign fac_hi = fhi_q[ccc_pkg::NUM_W];

	ccc_back u_back (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(d_valid), .quo(d_quo),
		.ctl_in(d_ctl), .factor({fac_hi, fac_lo}), .cfg(cfg_q),
		.out_valid(out_valid), .out_beat(out_beat)
	);

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("stalled result changed");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_beat.status <= ccc_pkg::ST_ZERO_DIV)
		else $error("illegal status code");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.status == ccc_pkg::ST_ZERO_DIV |->
		out_beat.conductivity == cfg_q.result_max)
		else $error("zero divisor result is not the max");
`endif

endmodule
